[rtl/rssc_pkg.sv]
// Shared types and constants for the rolling shift symbol codec.
`timescale 1ns / 1ps
package rssc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd3;

  localparam logic [63:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0] ALPHA_HIGH_RST = 64'h4645444342413938;
  localparam logic [4:0]  ALPHA_LEN_RST  = 5'd16;
  localparam logic [30:0] SEED_RST       = 31'd0;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef struct packed {
    logic       command;
    logic       first_of_stream;
    logic [7:0] byte_in;
    logic [7:0] symbol_first;
    logic [7:0] symbol_second;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol_high;
    logic [7:0] symbol_low;
    logic [7:0] byte_out;
  } out_item_t;

  typedef struct packed {
    logic       command;
    logic [3:0] shift;
    logic [7:0] byte_in;
    logic [7:0] symbol_first;
    logic [7:0] symbol_second;
  } work_item_t;

  typedef struct packed {
    logic [127:0] alphabet;
    logic [4:0]   radix;
  } codec_cfg_t;

endpackage

[rtl/rssc_seed_mod.sv]
// Bit-serial reduction of the start seed modulo the alphabet length.
`timescale 1ns / 1ps
module rssc_seed_mod
  import rssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic [30:0] seed,
  input  logic [4:0]  radix,
  output logic [3:0]  seed_mod,
  output logic        busy
);

  logic        busy_r, busy_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [4:0]  trial;
  logic [4:0]  trial_red;

  always_comb begin
    trial     = {rem_r, seed[bit_r]};
    trial_red = (trial >= radix) ? (trial - radix) : trial;
    busy_nxt  = busy_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    if (restart) begin
      busy_nxt = 1'b1;
      bit_nxt  = 5'd30;
      rem_nxt  = 4'd0;
    end else if (busy_r) begin
      rem_nxt = trial_red[3:0];
      bit_nxt = bit_r - 5'd1;
      if (bit_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      bit_r  <= 5'd30;
      rem_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign seed_mod = rem_r;
  assign busy     = busy_r;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, rem_r} < radix))
    else $error("seed remainder out of range");

endmodule

[rtl/rssc_front.sv]
// Front end: accepts transactions, tracks the rolling shift, feeds the queue.
`timescale 1ns / 1ps
module rssc_front
  import rssc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  logic [4:0] radix,
  input  logic [3:0] seed_mod,
  input  logic       seed_busy,
  input  logic       cfg_we,
  input  logic       q_full,
  output logic       push,
  output work_item_t push_data
);

  logic [3:0] shift_r;
  logic [3:0] shift_red;
  logic [3:0] shift_sel;
  logic [4:0] shift_inc;

  function automatic logic [3:0] mod_small(input logic [3:0] v, input logic [4:0] n);
    logic [4:0] rem;
    logic [4:0] t;
    rem = 5'd0;
    for (int i = 3; i >= 0; i--) begin
      t   = {rem[3:0], v[i]};
      rem = (t >= n) ? (t - n) : t;
    end
    return rem[3:0];
  endfunction

  assign in_stall  = seed_busy || q_full || cfg_we;
  assign push      = in_valid && !in_stall;
  assign shift_red = mod_small(shift_r, radix);
  assign shift_sel = in_data.first_of_stream ? seed_mod : shift_red;
  assign shift_inc = {1'b0, shift_sel} + 5'd1;

  always_comb begin
    push_data.command       = in_data.command;
    push_data.shift         = shift_sel;
    push_data.byte_in       = in_data.byte_in;
    push_data.symbol_first  = in_data.symbol_first;
    push_data.symbol_second = in_data.symbol_second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 4'd0;
    end else if (push) begin
      shift_r <= (shift_inc == radix) ? 4'd0 : shift_inc[3:0];
    end
  end

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ({1'b0, shift_sel} < radix))
    else $error("rolling shift not below alphabet length");

endmodule

[rtl/rssc_queue.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module rssc_queue
  import rssc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  work_item_t push_data,
  output logic       full,
  input  logic       pop,
  output work_item_t pop_data,
  output logic       nonempty
);

  work_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;

  assign full     = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty |-> !pop)
    else $error("pop from empty queue");

endmodule

[rtl/rssc_back.sv]
// Back end: serial divide, symbol lookup and search, result register.
`timescale 1ns / 1ps
module rssc_back
  import rssc_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  codec_cfg_t cfg,
  input  logic       q_valid,
  input  work_item_t q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_DIVQ = 4'b0010,
    BK_DIVM = 4'b0100,
    BK_FIN  = 4'b1000
  } bk_state_t;

  bk_state_t  state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [3:0] rdig_r, rdig_nxt;
  work_item_t work_r, work_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic [4:0] trial;
  logic       trial_ge;
  logic [4:0] trial_red;
  logic       out_load;
  out_item_t  result;
  logic [3:0] idx_first;
  logic [3:0] idx_second;
  logic [3:0] dig_first;
  logic [3:0] dig_second;
  logic [9:0] dec_sum;

  function automatic logic [7:0] sym_at(input logic [127:0] alpha, input logic [3:0] idx);
    return alpha[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] add_mod(input logic [3:0] a, input logic [3:0] b,
                                         input logic [4:0] n);
    logic [4:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= n) begin
      sum = sum - n;
    end
    return sum[3:0];
  endfunction

  function automatic logic [3:0] sub_mod(input logic [3:0] a, input logic [3:0] b,
                                         input logic [4:0] n);
    logic [5:0] dif;
    dif = {2'b00, a} + {1'b0, n} - {2'b00, b};
    if (dif >= {1'b0, n}) begin
      dif = dif - {1'b0, n};
    end
    return dif[3:0];
  endfunction

  function automatic logic [3:0] find_idx(input logic [127:0] alpha, input logic [7:0] sym,
                                          input logic [4:0] n);
    logic [3:0] found;
    found = 4'd0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if ((5'(i) < n) && (sym_at(alpha, 4'(i)) == sym)) begin
        found = 4'(i);
      end
    end
    return found;
  endfunction

  assign trial     = {rem_r, quo_r[7]};
  assign trial_ge  = (trial >= cfg.radix);
  assign trial_red = trial_ge ? (trial - cfg.radix) : trial;

  assign idx_first  = find_idx(cfg.alphabet, work_r.symbol_first, cfg.radix);
  assign idx_second = find_idx(cfg.alphabet, work_r.symbol_second, cfg.radix);
  assign dig_first  = sub_mod(idx_first, work_r.shift, cfg.radix);
  assign dig_second = sub_mod(idx_second, work_r.shift, cfg.radix);
  assign dec_sum    = 10'(dig_first) * 10'(cfg.radix) + 10'(dig_second);

  always_comb begin
    if (work_r.command == CMD_ENCODE) begin
      result.symbol_high = sym_at(cfg.alphabet, add_mod(rem_r, work_r.shift, cfg.radix));
      result.symbol_low  = sym_at(cfg.alphabet, add_mod(rdig_r, work_r.shift, cfg.radix));
      result.byte_out    = 8'd0;
    end else begin
      result.symbol_high = 8'd0;
      result.symbol_low  = 8'd0;
      result.byte_out    = dec_sum[7:0];
    end
  end

  assign out_load = (state_r == BK_FIN) && (!out_valid_r || !out_stall);
  assign q_pop    = (state_r == BK_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    rdig_nxt      = rdig_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          work_nxt = q_data;
          quo_nxt  = q_data.byte_in;
          rem_nxt  = 4'd0;
          cnt_nxt  = 3'd0;
          state_nxt = (q_data.command == CMD_ENCODE) ? BK_DIVQ : BK_FIN;
        end
      end
      BK_DIVQ: begin
        quo_nxt = {quo_r[6:0], trial_ge};
        rem_nxt = trial_red[3:0];
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          rdig_nxt  = trial_red[3:0];
          rem_nxt   = 4'd0;
          state_nxt = BK_DIVM;
        end
      end
      BK_DIVM: begin
        quo_nxt = {quo_r[6:0], trial_ge};
        rem_nxt = trial_red[3:0];
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    rdig_r     <= rdig_nxt;
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_DIVQ) || (state_r == BK_DIVM)) |-> ({1'b0, rem_r} < cfg.radix))
    else $error("divider remainder not below radix");

endmodule

[rtl/rolling_shift_symbol_codec.sv]
// Top level of the rolling shift symbol codec: config registers and block wiring.
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_stall   in_item_t (command, first_of_stream, byte, symbols)
//   out_*       output     out_valid/out_stall out_item_t (symbol_high, symbol_low, byte_out)
//   cfg_*       input      cfg_we              cfg_index, cfg_wdata (64 bits)
//
// In the back end an encode runs a queue pop, two 8-step serial divides, then the result.
// A decode runs a queue pop, then the result; while in_stall is low the front end takes one
// transaction a cycle into a two-entry queue, so the serial divider sets the sustained rate.
// After reset and after every config write the seed is reduced modulo the alphabet length
// one bit a cycle over its 31 bits; in_stall is high during that pass.
// A stalled result stays in the output register while the queue keeps filling.
`timescale 1ns / 1ps
module rolling_shift_symbol_codec
  import rssc_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  logic [63:0] alpha_low_r;
  logic [63:0] alpha_high_r;
  logic [4:0]  alpha_len_r;
  logic [30:0] seed_r;
  logic [4:0]  radix;
  codec_cfg_t  cfg;
  logic [3:0]  seed_mod;
  logic        seed_busy;
  logic        q_full;
  logic        q_push;
  work_item_t  q_push_data;
  logic        q_pop;
  work_item_t  q_pop_data;
  logic        q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= ALPHA_LOW_RST;
      alpha_high_r <= ALPHA_HIGH_RST;
      alpha_len_r  <= ALPHA_LEN_RST;
      seed_r       <= SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_LOW:  alpha_low_r  <= cfg_wdata;
        CFG_ALPHA_HIGH: alpha_high_r <= cfg_wdata;
        CFG_ALPHA_LEN:  alpha_len_r  <= cfg_wdata[4:0];
        CFG_SEED:       seed_r       <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (alpha_len_r == 5'd0) begin
      radix = 5'd1;
    end else if (alpha_len_r > 5'(MAX_SYMBOLS)) begin
      radix = 5'(MAX_SYMBOLS);
    end else begin
      radix = alpha_len_r;
    end
    cfg.alphabet = {alpha_high_r, alpha_low_r};
    cfg.radix    = radix;
  end

  rssc_seed_mod u_seed_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_we),
    .seed     (seed_r),
    .radix    (radix),
    .seed_mod (seed_mod),
    .busy     (seed_busy)
  );

  rssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .radix     (radix),
    .seed_mod  (seed_mod),
    .seed_busy (seed_busy),
    .cfg_we    (cfg_we),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  rssc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .nonempty  (q_nonempty)
  );

  rssc_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_nonempty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
